// ===== design/bht_pkg.sv =====
// ============================================================================
// bht_pkg
// Shared widths, codes and interface types of the bucketed hash table.
// ============================================================================
package bht_pkg;

   // Default table geometry.
   localparam int DEF_BUCKETS = 16;
   localparam int DEF_SLOTS   = 16;

   // Fixed field widths.
   localparam int KEY_W     = 31;
   localparam int ACT_W     = 2;
   localparam int STAT_W    = 2;
   localparam int MOD_W     = 5;
   localparam int BKT_OUT_W = 4;

   // Configuration port.
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;
   localparam logic [MOD_W-1:0] BUCKET_COUNT_RESET = 5'd16;

   // Operation codes; any other code behaves as a search.
   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

   // Request to the remainder unit.
   typedef struct packed {
      logic             start;
      logic [KEY_W-1:0] key;
      logic [MOD_W-1:0] modulus;
   } mod_req_type;

   // Answer from the remainder unit.
   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] rem;
   } mod_rsp_type;

endpackage

// ===== design/bht_mod.sv =====
// ============================================================================
// bht_mod
// Bit-serial remainder unit: key modulo bucket count, one key bit per cycle.
// ============================================================================
module bht_mod import bht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type req,
   output mod_rsp_type rsp
);

   localparam int CNT_W = $clog2(KEY_W);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MOD_W-1:0] rem_ff, rem_in;
   logic [MOD_W-1:0] m_ff, m_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [MOD_W:0]   trial;

   assign trial = {rem_ff, key_ff[KEY_W-1]};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      m_in      = m_ff;
      key_in    = key_ff;
      if (req.start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         rem_in    = '0;
         m_in      = req.modulus;
         key_in    = req.key;
      end else if (active_ff) begin
         // Restoring step: the partial remainder stays below the modulus.
         if (trial >= {1'b0, m_ff}) begin
            rem_in = MOD_W'(trial - {1'b0, m_ff});
         end else begin
            rem_in = trial[MOD_W-1:0];
         end
         key_in = {key_ff[KEY_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(KEY_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      m_ff   <= m_in;
      key_ff <= key_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ===== design/bht_ctrl.sv =====
// ============================================================================
// bht_ctrl
// Operation sequencer with the fill-count memory and the slot-key memory.
// ============================================================================
module bht_ctrl import bht_pkg::*; #(
   parameter int BUCKETS = DEF_BUCKETS,
   parameter int SLOTS   = DEF_SLOTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ACT_W-1:0]     req_action,
   input  logic [KEY_W-1:0]     req_key,
   input  logic [MOD_W-1:0]     modulus,
   output mod_req_type          mod_req,
   input  mod_rsp_type          mod_rsp,
   output logic                 rsp_valid,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [BKT_OUT_W-1:0] rsp_bucket
);

   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int FILL_W = $clog2(SLOTS + 1);
   localparam int DEPTH  = BUCKETS * SLOTS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_DIV   = 8'b0000_0100,
      S_FILL  = 8'b0000_1000,
      S_SCAN  = 8'b0001_0000,
      S_SHIFT = 8'b0010_0000,
      S_TAIL  = 8'b0100_0000
   } state_type;

   state_type state_ff, state_in;

   logic [BKT_W-1:0]     clr_ff, clr_in;
   logic                 pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]     action_ff, action_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [MOD_W-1:0]     bkt_ff, bkt_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [FILL_W-1:0]    n_ff, n_in;
   logic [FILL_W-1:0]    idx_ff, idx_in;
   logic [FILL_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [STAT_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [BKT_OUT_W-1:0] rsp_bucket_ff, rsp_bucket_in;

   // Fill-count memory.
   logic [FILL_W-1:0] fill_mem [BUCKETS];
   logic              fill_we, fill_re;
   logic [BKT_W-1:0]  fill_waddr, fill_raddr;
   logic [FILL_W-1:0] fill_wdata, fill_rdata_ff;

   // Slot-key memory.
   logic [KEY_W-1:0]  slot_mem [DEPTH];
   logic              slot_we, slot_re;
   logic [ADDR_W-1:0] slot_waddr, slot_raddr;
   logic [KEY_W-1:0]  slot_wdata, slot_rdata_ff;

   logic [BKT_W-1:0]  bkt_idx;

   assign bkt_idx = BKT_W'(bkt_ff);
   assign busy    = (state_ff != S_IDLE);

   always_comb begin
      logic              finish;
      logic [STAT_W-1:0] status;
      finish        = 1'b0;
      status        = ST_OK;
      state_in      = state_ff;
      clr_in        = clr_ff;
      pend_in       = pend_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      bkt_in        = bkt_ff;
      base_in       = base_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = rsp_bucket_ff;
      mod_req.start   = 1'b0;
      mod_req.key     = req_key;
      mod_req.modulus = modulus;
      fill_we    = 1'b0;
      fill_waddr = bkt_idx;
      fill_wdata = '0;
      fill_re    = 1'b0;
      fill_raddr = BKT_W'(mod_rsp.rem);
      slot_we    = 1'b0;
      slot_waddr = '0;
      slot_wdata = '0;
      slot_re    = 1'b0;
      slot_raddr = base_ff + ADDR_W'(idx_ff);

      unique case (state_ff)
         S_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               action_in     = req_action;
               key_in        = req_key;
               mod_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (mod_rsp.done) begin
               bkt_in   = mod_rsp.rem;
               base_in  = ADDR_W'(32'(mod_rsp.rem) * SLOTS);
               fill_re  = 1'b1;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            n_in    = fill_rdata_ff;
            idx_in  = '0;
            pend_in = 1'b0;
            unique case (action_ff)
               ACT_INSERT: begin
                  finish = 1'b1;
                  if (fill_rdata_ff >= FILL_W'(SLOTS)) begin
                     status = ST_FULL;
                  end else begin
                     slot_we    = 1'b1;
                     slot_waddr = base_ff + ADDR_W'(fill_rdata_ff);
                     slot_wdata = key_ff;
                     fill_we    = 1'b1;
                     fill_wdata = fill_rdata_ff + 1'b1;
                  end
               end
               default: begin
                  state_in = S_SCAN;
               end
            endcase
         end
         S_SCAN: begin
            // One read issued per cycle; its data is compared in the next cycle.
            if (pend_ff && (slot_rdata_ff == key_ff)) begin
               pend_in = 1'b0;
               if (action_ff == ACT_REMOVE) begin
                  idx_in   = pend_idx_ff + 1'b1;
                  state_in = S_SHIFT;
               end else begin
                  finish = 1'b1;
               end
            end else if (idx_ff < n_ff) begin
               slot_re     = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               idx_in      = idx_ff + 1'b1;
            end else begin
               finish = 1'b1;
               status = ST_ABSENT;
            end
         end
         S_SHIFT: begin
            // Each entry read is written back one slot lower next cycle.
            if (pend_ff) begin
               slot_we    = 1'b1;
               slot_waddr = base_ff + ADDR_W'(pend_idx_ff - 1'b1);
               slot_wdata = slot_rdata_ff;
            end
            if (idx_ff < n_ff) begin
               slot_re     = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               idx_in      = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_TAIL;
               end
            end
         end
         S_TAIL: begin
            slot_we    = 1'b1;
            slot_waddr = base_ff + ADDR_W'(n_ff - 1'b1);
            fill_we    = 1'b1;
            fill_wdata = n_ff - 1'b1;
            finish     = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_bucket_in = bkt_ff[BKT_OUT_W-1:0];
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      if (fill_re) begin
         fill_rdata_ff <= fill_mem[fill_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_re) begin
         slot_rdata_ff <= slot_mem[slot_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      key_ff        <= key_in;
      bkt_ff        <= bkt_in;
      base_ff       <= base_in;
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_bucket = rsp_bucket_ff;

   // A result strobe lasts a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   // The remainder unit only answers while the sequencer waits for it.
   a_mod_done_in_div: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (state_ff == S_DIV))
      else $error("remainder answer outside the divide phase");

   // Fill counts written never exceed the slot count.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> (fill_wdata <= FILL_W'(SLOTS)))
      else $error("fill count above slot count");

   // Slot writes only happen while an operation is being worked on.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) || (state_ff == S_CLEAR)) |-> !slot_we)
      else $error("slot write outside an operation");

endmodule

// ===== design/bucketed_hash_table.sv =====
// ============================================================================
// bucketed_hash_table
// Hash table of 31-bit keys in buckets of fixed slot count, with APB-style
// configuration of the bucket count.
// ============================================================================
// A word is accepted when start is high and busy is low; exactly one result
// word follows, shown for a single cycle with rsp_valid, and the receiver
// cannot stall it. After reset the block clears the fill counts of all
// buckets and holds busy high meanwhile. Each word first runs through a
// bit-serial remainder unit (one key bit per cycle), then one read of the
// fill-count memory; an insert then stores its key, unless the bucket is
// full, and shows its result. A search or a remove instead scans the
// bucket at one slot-memory read per cycle; a remove that hits then moves
// the later keys down one slot per cycle and clears the vacated slot. busy
// falls in the cycle in which the result is shown, so the next word may be
// accepted while that result is on the ports.
// ============================================================================
module bucketed_hash_table import bht_pkg::*; #(
   parameter int BUCKETS = DEF_BUCKETS,
   parameter int SLOTS   = DEF_SLOTS
) (
   input  logic                 clock,
   input  logic                 reset,
   // Command channel.
   input  logic                 start,
   output logic                 busy,
   input  logic [ACT_W-1:0]     req_action,
   input  logic [KEY_W-1:0]     req_key,
   // Result channel.
   output logic                 rsp_valid,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [BKT_OUT_W-1:0] rsp_bucket,
   // Configuration port.
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [CSR_DW-1:0]    csr_pwdata,
   output logic [CSR_DW-1:0]    csr_prdata,
   output logic                 csr_pready
);

   // Largest modulus in use: the bucket count saturates at BUCKETS, or at MAX_FIELD if that is smaller.
   localparam int MAX_FIELD = (1 << MOD_W) - 1;
   localparam logic [MOD_W-1:0] MAX_MOD =
      MOD_W'((BUCKETS < MAX_FIELD) ? BUCKETS : MAX_FIELD);

   logic [MOD_W-1:0] bucket_count_ff, bucket_count_in;
   logic [MOD_W-1:0] modulus;
   logic             csr_write;
   logic [0:0]       csr_index;
   mod_req_type      mod_req;
   mod_rsp_type      mod_rsp;

   // The register sits at byte address zero; the word above it is unused.
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      bucket_count_in = bucket_count_ff;
      if (csr_write && (csr_index == REG_BUCKET_COUNT)) begin
         bucket_count_in = csr_pwdata[MOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RESET;
      end else begin
         bucket_count_ff <= bucket_count_in;
      end
   end

   assign csr_prdata = (csr_index == REG_BUCKET_COUNT) ?
                       CSR_DW'(bucket_count_ff) : '0;

   // A bucket count of zero is taken as one; one above MAX_MOD is
   // limited to it. Stored keys are never rehashed when it changes.
   always_comb begin
      if (bucket_count_ff == '0) begin
         modulus = MOD_W'(1);
      end else if (bucket_count_ff > MAX_MOD) begin
         modulus = MAX_MOD;
      end else begin
         modulus = bucket_count_ff;
      end
   end

   bht_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   bht_ctrl #(
      .BUCKETS (BUCKETS),
      .SLOTS   (SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_key    (req_key),
      .modulus    (modulus),
      .mod_req    (mod_req),
      .mod_rsp    (mod_rsp),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_bucket (rsp_bucket)
   );

endmodule
